/* rtl/core/grs_pkg.sv */
package grs_pkg;

    localparam int VALUE_W = 32;
    localparam int GSIZE_W = 5;
    localparam logic [GSIZE_W-1:0] GSIZE_RESET = 5'd2;

    typedef struct packed {
        logic accept;
        logic issue;
    } cmd_t;

    typedef struct packed {
        logic trigger;
        logic last_read;
    } sts_t;

endpackage

/* rtl/core/grs_ram.sv */
module grs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/grs_ctrl.sv */
module grs_ctrl
    import grs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    output logic out_valid,
    input  logic out_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   adv;

    assign adv = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd.accept     = 1'b0;
        cmd.issue      = 1'b0;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (sts.trigger)
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                if (adv)
                begin
                    cmd.issue      = 1'b1;
                    out_valid_next = 1'b1;
                    if (sts.last_read)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

/* rtl/core/grs_dpath.sv */
module grs_dpath
    import grs_pkg::*;
#(
    parameter int MAX_GROUP = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  cmd_t                      cmd,
    output sts_t                      sts,
    input  logic                      cfg_valid,
    input  logic [GSIZE_W-1:0]        group_size,
    input  logic signed [VALUE_W-1:0] value,
    input  logic                      end_of_sequence,
    output logic signed [VALUE_W-1:0] out_value,
    output logic                      burst_last,
    output logic                      sequence_last
);

    localparam int AW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
    localparam int CW = $clog2(MAX_GROUP + 1);
    localparam int KW = (CW > GSIZE_W) ? CW : GSIZE_W;

    logic [GSIZE_W-1:0] gsize_reg;
    logic [CW-1:0]      fill_reg;
    logic [CW-1:0]      fill_next;
    logic [CW-1:0]      rem_reg;
    logic [CW-1:0]      rem_next;
    logic [AW-1:0]      rd_ptr_reg;
    logic [AW-1:0]      rd_ptr_next;
    logic               rev_reg;
    logic               rev_next;
    logic               eos_reg;
    logic               eos_next;
    logic               burst_reg;
    logic               burst_next;
    logic               seq_reg;
    logic               seq_next;

    logic [KW-1:0]      gs_ext;
    logic [KW-1:0]      k_eff;
    logic [CW-1:0]      fill_c;
    logic [CW-1:0]      n_cnt;
    logic               full_group;
    logic [AW-1:0]      wr_addr;
    logic [VALUE_W-1:0] rd_data;

    assign gs_ext = KW'(gsize_reg);

    always_comb
    begin
        if (gs_ext == '0)
        begin
            k_eff = KW'(1);
        end
        else if (gs_ext > KW'(MAX_GROUP))
        begin
            k_eff = KW'(MAX_GROUP);
        end
        else
        begin
            k_eff = gs_ext;
        end
    end

    assign fill_c     = (fill_reg >= CW'(MAX_GROUP)) ? CW'(MAX_GROUP - 1) : fill_reg;
    assign n_cnt      = fill_c + CW'(1);
    assign full_group = (KW'(n_cnt) >= k_eff);
    assign wr_addr    = AW'(fill_c);

    assign sts.trigger   = full_group || end_of_sequence;
    assign sts.last_read = (rem_reg == CW'(1));

    always_comb
    begin
        fill_next   = fill_reg;
        rem_next    = rem_reg;
        rd_ptr_next = rd_ptr_reg;
        rev_next    = rev_reg;
        eos_next    = eos_reg;
        burst_next  = burst_reg;
        seq_next    = seq_reg;
        if (cmd.accept)
        begin
            if (full_group || end_of_sequence)
            begin
                fill_next   = '0;
                rem_next    = n_cnt;
                rev_next    = full_group;
                eos_next    = end_of_sequence;
                rd_ptr_next = full_group ? AW'(n_cnt - CW'(1)) : '0;
            end
            else
            begin
                fill_next = n_cnt;
            end
        end
        if (cmd.issue)
        begin
            rem_next    = rem_reg - CW'(1);
            rd_ptr_next = rev_reg ? (rd_ptr_reg - AW'(1)) : (rd_ptr_reg + AW'(1));
            burst_next  = (rem_reg == CW'(1));
            seq_next    = (rem_reg == CW'(1)) && eos_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gsize_reg <= GSIZE_RESET;
            fill_reg  <= '0;
            rem_reg   <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                gsize_reg <= group_size;
            end
            fill_reg <= fill_next;
            rem_reg  <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_ptr_reg <= rd_ptr_next;
        rev_reg    <= rev_next;
        eos_reg    <= eos_next;
        burst_reg  <= burst_next;
        seq_reg    <= seq_next;
    end

    grs_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (MAX_GROUP)
    ) u_buf (
        .clk   (clk),
        .we    (cmd.accept),
        .waddr (wr_addr),
        .wdata (value),
        .re    (cmd.issue),
        .raddr (rd_ptr_reg),
        .rdata (rd_data)
    );

    assign out_value     = rd_data;
    assign burst_last    = burst_reg;
    assign sequence_last = seq_reg;

endmodule

/* rtl/core/group_reverse_stream.sv */
// channel   signals                                          direction
// in        in_valid in_ready value end_of_sequence          input beats
// out       out_valid out_ready out_value burst_last
//           sequence_last                                    output beats
// cfg       cfg_valid cfg_ready group_size                   register write
//
// an input beat is taken while in_ready is high; a beat that closes a group or a
// sequence of n values then gives n output beats, one per cycle unless the output
// stalls, read back through the single buffer read port once the state enters ST_EMIT
// in_ready stays low while those reads are issued
// reset clears the fill count and sets group_size to 2
// output stalls hold the read port; the last beat may wait while input resumes
module group_reverse_stream
    import grs_pkg::*;
#(
    parameter int MAX_GROUP = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic signed [VALUE_W-1:0] value,
    input  logic                      end_of_sequence,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [VALUE_W-1:0] out_value,
    output logic                      burst_last,
    output logic                      sequence_last,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [GSIZE_W-1:0]        group_size
);

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    grs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    grs_dpath #(
        .MAX_GROUP (MAX_GROUP)
    ) u_dpath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .cfg_valid       (cfg_valid),
        .group_size      (group_size),
        .value           (value),
        .end_of_sequence (end_of_sequence),
        .out_value       (out_value),
        .burst_last      (burst_last),
        .sequence_last   (sequence_last)
    );

endmodule

/* rtl/core/grs_checker.sv */
module grs_checker
    import grs_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_ready,
    input logic                      end_of_sequence,
    input logic                      out_valid,
    input logic                      out_ready,
    input logic signed [VALUE_W-1:0] out_value,
    input logic                      burst_last,
    input logic                      sequence_last
);

    // stalled output beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_value)
            && $stable(burst_last) && $stable(sequence_last))
        else $error("output beat changed under stall");

    // end of sequence only on the end of a burst
    a_seq_burst: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && sequence_last |-> burst_last)
        else $error("sequence_last without burst_last");

    // end-of-sequence beat starts a burst, input held off
    a_eos_block: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && end_of_sequence |=> !in_ready)
        else $error("input taken after end of sequence");

    // a burst only begins while input is held off
    a_burst_start: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("output beat without a burst");

endmodule

bind group_reverse_stream grs_checker u_grs_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .end_of_sequence (end_of_sequence),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_value       (out_value),
    .burst_last      (burst_last),
    .sequence_last   (sequence_last)
);

/* tb/tb.sv */
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import grs_pkg::*;

    localparam int GROUP_DEPTH = 16;
    localparam int IDLE_LIMIT = 3000;
    localparam int DRAIN_CYCLES = 40;
    localparam int CFG_SETTLE = 20;
    localparam int LONG_STALL = 300;

    typedef struct packed {
        logic signed [VALUE_W-1:0] out_value;
        logic                      burst_last;
        logic                      sequence_last;
    } beat_t;

    class reorder_scoreboard;
        logic signed [VALUE_W-1:0] held_values [GROUP_DEPTH];
        int unsigned               held_count;
        logic [GSIZE_W-1:0]        size_setting;
        beat_t                     awaited[$];
        int                        errors;

        function new();
            held_count = 0;
            size_setting = GSIZE_RESET;
            errors = 0;
        endfunction

        function void set_size(logic [GSIZE_W-1:0] s);
            size_setting = s;
        endfunction

        function void note_input(logic signed [VALUE_W-1:0] v, logic eos);
            int unsigned k;
            int unsigned n;
            beat_t b;
            if (size_setting == '0)
                k = 1;
            else if (size_setting > GROUP_DEPTH)
                k = GROUP_DEPTH;
            else
                k = size_setting;
            if (held_count >= GROUP_DEPTH)
                held_count = GROUP_DEPTH - 1;
            held_values[held_count] = v;
            held_count++;
            n = held_count;
            if (n >= k)
            begin
                // full group goes out newest first
                for (int i = 0; i < n; i++)
                begin
                    b.out_value = held_values[n - 1 - i];
                    b.burst_last = (i == n - 1);
                    b.sequence_last = (i == n - 1) && eos;
                    awaited.push_back(b);
                end
                held_count = 0;
            end
            else if (eos)
            begin
                // partial tail keeps arrival order
                for (int i = 0; i < n; i++)
                begin
                    b.out_value = held_values[i];
                    b.burst_last = (i == n - 1);
                    b.sequence_last = (i == n - 1);
                    awaited.push_back(b);
                end
                held_count = 0;
            end
        endfunction

        task report(string what);
            $display("mismatch at %0t: %s", $realtime, what);
            errors++;
        endtask

        task check_result(beat_t got);
            beat_t want;
            if (awaited.size() == 0)
            begin
                report($sformatf("unexpected beat value %0d burst_last %0b sequence_last %0b",
                                 got.out_value, got.burst_last, got.sequence_last));
                return;
            end
            want = awaited.pop_front();
            if (got.out_value !== want.out_value || got.burst_last !== want.burst_last ||
                got.sequence_last !== want.sequence_last)
                report($sformatf("got %0d/%0b/%0b want %0d/%0b/%0b (value/burst/seq)",
                                 got.out_value, got.burst_last, got.sequence_last,
                                 want.out_value, want.burst_last, want.sequence_last));
        endtask

        task check_leftovers();
            if (awaited.size() != 0)
                report($sformatf("%0d expected beats never arrived", awaited.size()));
        endtask
    endclass

    logic                      clk;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      in_ready;
    logic signed [VALUE_W-1:0] value = '0;
    logic                      end_of_sequence = 1'b0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic signed [VALUE_W-1:0] out_value;
    logic                      burst_last;
    logic                      sequence_last;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [GSIZE_W-1:0]        group_size = '0;

    reorder_scoreboard sb = new();

    int  send_gap_pct = 0;
    int  recv_gap_pct = 0;
    int  hold_left = 0;
    bit  offering = 1'b0;
    int  in_beats = 0;
    int  out_beats = 0;
    int  cfg_writes = 0;
    int  idle_cycles = 0;

    group_reverse_stream #(
        .MAX_GROUP(GROUP_DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .value(value),
        .end_of_sequence(end_of_sequence),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_value(out_value),
        .burst_last(burst_last),
        .sequence_last(sequence_last),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .group_size(group_size)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // output side: check accepted beats, then pick next out_ready
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            sb.check_result('{out_value, burst_last, sequence_last});
            out_beats++;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(0, 99) >= recv_gap_pct);
        end
    end

    initial
    begin
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("watchdog: nothing accepted for %0d cycles", IDLE_LIMIT);
        $display("status: fail");
        $finish;
    end

    task stop_sending();
        if (offering)
        begin
            in_valid <= 1'b0;
            offering = 1'b0;
        end
    endtask

    task send_item(logic signed [VALUE_W-1:0] v, logic eos);
        while ($urandom_range(0, 99) < send_gap_pct)
        begin
            stop_sending();
            @(posedge clk);
        end
        in_valid <= 1'b1;
        offering = 1'b1;
        value <= v;
        end_of_sequence <= eos;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_input(v, eos);
        in_beats++;
    endtask

    task wait_drained();
        stop_sending();
        while (sb.awaited.size() != 0)
            @(posedge clk);
    endtask

    task configure(logic [GSIZE_W-1:0] s);
        wait_drained();
        // a beat that only stores may still be in flight
        repeat (CFG_SETTLE) @(posedge clk);
        cfg_valid <= 1'b1;
        group_size <= s;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        sb.set_size(s);
        cfg_writes++;
    endtask

    function automatic logic signed [VALUE_W-1:0] random_value();
        case ($urandom_range(0, 7))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return '0;
            3: return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [GSIZE_W-1:0] pick_size();
        case ($urandom_range(0, 19))
            0: return '0;
            1: return GSIZE_W'(GROUP_DEPTH);
            2: return GSIZE_W'($urandom_range(GROUP_DEPTH + 1, 31));
            3: return GSIZE_W'(1);
            default: return GSIZE_W'($urandom_range(2, 6));
        endcase
    endfunction

    task run_phase(int s_gap, int r_gap, int quota);
        int sent;
        int len;
        int mid;
        send_gap_pct = s_gap;
        recv_gap_pct = r_gap;
        sent = 0;
        while (sent < quota)
        begin
            if ($urandom_range(0, 2) == 0)
                configure(pick_size());
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            mid = (len > 1 && $urandom_range(0, 5) == 0) ? $urandom_range(1, len - 1) : 0;
            for (int i = 0; i < len; i++)
            begin
                // size change while a group is partly held
                if (mid != 0 && i == mid)
                    configure(pick_size());
                send_item(random_value(), (i == len - 1) || ($urandom_range(0, 39) == 0));
                sent++;
            end
        end
        wait_drained();
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset size of two, extremes of the value range
        send_item(32'h7fff_ffff, 1'b0);
        send_item(32'h8000_0000, 1'b0);
        send_item('0, 1'b1);
        // a full group that also carries the end flag
        send_item('1, 1'b0);
        send_item(32'sd1, 1'b1);
        // size zero acts as pass-through
        configure('0);
        send_item(32'sd5, 1'b0);
        send_item(-32'sd5, 1'b1);
        // above range saturates, short sequence leaves a tail
        configure(GSIZE_W'(31));
        send_item(32'sd10, 1'b0);
        send_item(32'sd20, 1'b0);
        send_item(32'sd30, 1'b1);
        // lowered size flushes the held values reversed
        configure(GSIZE_W'(5));
        send_item(32'sd100, 1'b0);
        send_item(32'sd200, 1'b0);
        send_item(32'sd300, 1'b0);
        configure(GSIZE_W'(2));
        send_item(32'sd400, 1'b0);
        configure(GSIZE_W'(1));
        send_item(32'sd123, 1'b0);
        send_item('0, 1'b1);
        wait_drained();

        run_phase(37, 75, 40);
        configure(GSIZE_W'(GROUP_DEPTH));
        run_phase(75, 37, 40);
        run_phase(0, 0, 40);

        // long output stall with the sender still offering
        configure(GSIZE_W'(4));
        hold_left = LONG_STALL;
        for (int i = 0; i < 30; i++)
            send_item(random_value(), i == 29);
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge clk);
        sb.check_leftovers();
        $display("run covered %0d input beats, %0d output beats, %0d size writes",
                 in_beats, out_beats, cfg_writes);
        $display("sizes from zero to above range, mid-group size drops, three idle mixes, one long stall");
        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
